// ===== rtl/lfr_pkg.sv =====
// Shared constants and types for the LRU frame replacer.
package lfr_pkg;

  localparam int FRAME_W = 6;
  localparam int COUNT_W = 7;
  localparam int REQ_W = 2;
  localparam int DEFAULT_NUM_FRAMES = 64;

  localparam logic [REQ_W-1:0] REQ_VICTIM = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PIN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_UNPIN = 2'd2;

  // Broadcast control seen by every cell of the row.
  typedef struct packed {
    logic               shift_all;
    logic               pin_go;
    logic               unpin_go;
    logic [FRAME_W-1:0] frame;
  } cell_ctl_t;

endpackage

// ===== rtl/lfr_frame_replacer_core.sv =====
// The result word is registered: it appears in the cycle after its request word is accepted.
// Throughput: one request per cycle while the result side does not stall;
// the whole row of cells matches and shifts together.
// Reset empties the set at once (occupied bits cleared), no clearing pass.
// Frame numbers in the cells are not reset; empty cells are never read.
module lru_frame_replacer_core #(
  parameter int NUM_FRAMES = lfr_pkg::DEFAULT_NUM_FRAMES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [lfr_pkg::REQ_W-1:0]   req_type,
  input  logic [lfr_pkg::FRAME_W-1:0] frame,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [lfr_pkg::FRAME_W-1:0] victim_frame,
  output logic [lfr_pkg::COUNT_W-1:0] evictable_count
);
  import lfr_pkg::*;

  cell_ctl_t             ctl;
  logic [FRAME_W-1:0]    cell_data [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] cell_valid;
  logic [NUM_FRAMES-1:0] cell_match;
  logic [NUM_FRAMES:0]   kill;
  logic                  in_accept;
  logic                  in_range;
  logic                  present;
  logic                  remove;
  logic [COUNT_W-1:0]    count;
  logic [COUNT_W-1:0]    count_next;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign in_range  = 32'(frame) < 32'(NUM_FRAMES);
  assign present   = |cell_match;

  always_comb begin
    ctl.frame     = frame;
    ctl.shift_all = in_accept && (req_type == REQ_VICTIM) && cell_valid[0];
    ctl.pin_go    = in_accept && (req_type == REQ_PIN) && in_range;
    ctl.unpin_go  = in_accept && (req_type == REQ_UNPIN) && in_range && !present
                    && !cell_valid[NUM_FRAMES-1];
  end

  assign remove     = ctl.shift_all | (ctl.pin_go & present);
  assign count_next = count + COUNT_W'(ctl.unpin_go) - COUNT_W'(remove);

  assign kill[0] = 1'b0;

  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    logic [FRAME_W-1:0] nb_data;
    logic               nb_valid;
    logic               prev_valid;

    if (i == NUM_FRAMES - 1) begin : g_last
      assign nb_data  = '0;
      assign nb_valid = 1'b0;
    end else begin : g_mid
      assign nb_data  = cell_data[i+1];
      assign nb_valid = cell_valid[i+1];
    end

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_tail
      assign prev_valid = cell_valid[i-1];
    end

    lfr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .nb_data    (nb_data),
      .nb_valid   (nb_valid),
      .prev_valid (prev_valid),
      .kill_in    (kill[i]),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .match      (cell_match[i]),
      .kill_out   (kill[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      found           <= ctl.shift_all;
      victim_frame    <= ctl.shift_all ? cell_data[0] : '0;
      evictable_count <= count_next;
    end
  end

  // Occupied cells always form an unbroken run from the oldest end.
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + NUM_FRAMES'(1)) & cell_valid) == '0)
    else $error("occupied cells are not contiguous");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(cell_valid))
    else $error("entry count disagrees with occupied cells");

  a_victim_found: assert property (@(posedge clk) disable iff (rst)
    in_accept && (req_type == REQ_VICTIM) && cell_valid[0] |=> out_valid && found)
    else $error("victim request on a nonempty set did not evict");

  a_no_dup: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_match) <= 1)
    else $error("frame held in more than one cell");

endmodule

// ===== rtl/lfr_cell.sv =====
// One slot of the recency row: holds a frame number and its occupied bit.
module lfr_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  lfr_pkg::cell_ctl_t        ctl,
  input  logic [lfr_pkg::FRAME_W-1:0] nb_data,
  input  logic                      nb_valid,
  input  logic                      prev_valid,
  input  logic                      kill_in,
  output logic [lfr_pkg::FRAME_W-1:0] data,
  output logic                      valid,
  output logic                      match,
  output logic                      kill_out
);
  import lfr_pkg::*;

  logic shift;
  logic load;

  assign match    = valid && (data == ctl.frame);
  assign kill_out = kill_in | match;

  // Close the gap: the matching slot and every younger one take the next slot; a victim request shifts every slot.
  assign shift = ctl.shift_all | (ctl.pin_go & (kill_in | match));
  // Append at the first empty slot.
  assign load  = ctl.unpin_go & ~valid & prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= nb_valid;
    end else if (load) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= nb_data;
    end else if (load) begin
      data <= ctl.frame;
    end
  end

endmodule

// ===== dv/lru_frame_replacer_core_test.sv =====
// Self-checking testbench for lru_frame_replacer_core with its own LRU predictor.
`timescale 1ns / 100ps

module lru_frame_replacer_core_test;
  import lfr_pkg::*;

  localparam int N_FRAMES = DEFAULT_NUM_FRAMES;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
  localparam realtime CLK_PERIOD = 12.0;
  localparam realtime RUN_LIMIT = 2_000_000.0;

  typedef enum int { PACE_RANDOM, PACE_NONE, PACE_LIGHT } pace_e;

  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] victim_frame;
    logic [COUNT_W-1:0] evictable_count;
  } replacer_answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [REQ_W-1:0]   req_type = '0;
  logic [FRAME_W-1:0] frame = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               found;
  logic [FRAME_W-1:0] victim_frame;
  logic [COUNT_W-1:0] evictable_count;

  // predicted replacer state: oldest unpinned frame at the front
  logic [FRAME_W-1:0] lru_order[$];
  bit                 resident[N_FRAMES];
  replacer_answer_t   answer_q[$];

  pace_e tx_pace = PACE_RANDOM;
  pace_e rx_pace = PACE_RANDOM;
  int    freeze_req = 0;
  logic  rx_frozen = 1'b0;

  int mismatches = 0;
  int checked = 0;
  int kind_seen[4];
  int evictions = 0;
  int peak_count = 0;

  lru_frame_replacer_core #(
    .NUM_FRAMES(N_FRAMES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .frame(frame),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .found(found),
    .victim_frame(victim_frame),
    .evictable_count(evictable_count)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("lru_frame_replacer_core regression: fail");
    $finish;
  end

  function automatic int draw_wait(pace_e p);
    case (p)
      PACE_NONE:  return 0;
      PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
      default:    return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic replacer_answer_t apply_replacer_request(logic [REQ_W-1:0] kind,
                                                             logic [FRAME_W-1:0] fr);
    replacer_answer_t a;
    a = '0;
    kind_seen[kind]++;
    case (kind)
      REQ_VICTIM: begin
        if (lru_order.size() > 0) begin
          a.found = 1'b1;
          a.victim_frame = lru_order.pop_front();
          resident[a.victim_frame] = 1'b0;
          evictions++;
        end
      end
      REQ_PIN: begin
        if (resident[fr]) begin
          foreach (lru_order[i]) begin
            if (lru_order[i] == fr) begin
              lru_order.delete(i);
              break;
            end
          end
          resident[fr] = 1'b0;
        end
      end
      REQ_UNPIN: begin
        // present frames keep their place in the order
        if (!resident[fr] && lru_order.size() < N_FRAMES) begin
          lru_order.push_back(fr);
          resident[fr] = 1'b1;
        end
      end
      default: ;
    endcase
    a.evictable_count = COUNT_W'(lru_order.size());
    if (lru_order.size() > peak_count) peak_count = lru_order.size();
    return a;
  endfunction

  // Leaves in_valid high after acceptance; the caller drops it before idling.
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [FRAME_W-1:0] fr);
    int gap;
    gap = draw_wait(tx_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    frame <= fr;
    do @(posedge clk); while (in_stall);
    answer_q.push_back(apply_replacer_request(kind, fr));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
  endtask

  // result side: per-word stall draw, plus the long hold-off when frozen
  initial begin : result_side
    int hold;
    replacer_answer_t want;
    replacer_answer_t got;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = '{found, victim_frame, evictable_count};
        if (answer_q.size() == 0) begin
          $error("result word with nothing expected: found %0d victim_frame %0d count %0d",
                 got.found, got.victim_frame, got.evictable_count);
          mismatches++;
        end else begin
          want = answer_q.pop_front();
          checked++;
          if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatches++;
          end
          if (got.victim_frame !== want.victim_frame) begin
            $error("victim_frame: expected %0d, got %0d", want.victim_frame, got.victim_frame);
            mismatches++;
          end
          if (got.evictable_count !== want.evictable_count) begin
            $error("evictable_count: expected %0d, got %0d",
                   want.evictable_count, got.evictable_count);
            mismatches++;
          end
        end
        hold = draw_wait(rx_pace);
      end else if (hold > 0) begin
        hold--;
      end
      out_stall <= (hold > 0) || rx_frozen;
    end
  end

  initial begin : rx_freeze
    int n;
    forever begin
      @(posedge clk);
      if (freeze_req > 0) begin
        n = freeze_req;
        freeze_req = 0;
        rx_frozen <= 1'b1;
        repeat (n) @(posedge clk);
        rx_frozen <= 1'b0;
      end
    end
  end

  task automatic test_directed();
    send_req(REQ_VICTIM, 6'd0);     // victim on empty set
    send_req(REQ_PIN, 6'd5);        // pin of absent frame
    send_req(REQ_UNPIN, 6'd0);
    send_req(REQ_UNPIN, 6'd63);
    send_req(REQ_UNPIN, 6'd0);      // already present, keeps its place
    send_req(REQ_UNKNOWN, 6'd42);
    send_req(REQ_UNPIN, 6'd21);
    send_req(REQ_UNPIN, 6'd42);
    send_req(REQ_PIN, 6'd21);       // pin from the middle
    send_req(REQ_PIN, 6'd21);
    send_req(REQ_VICTIM, 6'd63);    // frame field ignored
    send_req(REQ_UNPIN, 6'd0);
    send_req(REQ_VICTIM, 6'd0);
    send_req(REQ_VICTIM, 6'd0);
    send_req(REQ_VICTIM, 6'd0);
    send_req(REQ_VICTIM, 6'd0);
    send_req(REQ_UNKNOWN, 6'd63);
    send_req(REQ_PIN, 6'd63);
    send_req(REQ_UNPIN, 6'd63);
    send_req(REQ_PIN, 6'd63);       // pin of the only entry
    send_req(REQ_VICTIM, 6'd0);
    wait_drained();
  endtask

  task automatic test_fill_and_drain();
    logic [FRAME_W-1:0] perm[N_FRAMES];
    logic [FRAME_W-1:0] t;
    int j;
    foreach (perm[i]) perm[i] = FRAME_W'(i);
    foreach (perm[i]) begin
      j = $urandom_range(0, N_FRAMES - 1);
      t = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    rx_pace = PACE_LIGHT;
    foreach (perm[i]) send_req(REQ_UNPIN, perm[i]);
    // full set, frame present
    send_req(REQ_UNPIN, FRAME_W'($urandom_range(0, N_FRAMES - 1)));
    repeat (N_FRAMES + 1) send_req(REQ_VICTIM, FRAME_W'($urandom_range(0, 63)));
    wait_drained();
  endtask

  task automatic test_random_mix();
    int unpin_pct;
    int roll;
    logic [REQ_W-1:0] kind;
    logic [FRAME_W-1:0] fr;
    for (int blk = 0; blk < 3; blk++) begin
      // swing the occupancy up and down between blocks
      unpin_pct = (blk % 2 == 0) ? $urandom_range(55, 80) : $urandom_range(20, 40);
      tx_pace = pace_e'($urandom_range(0, 2));
      rx_pace = pace_e'($urandom_range(0, 2));
      repeat (50) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) kind = REQ_UNKNOWN;
        else if (roll < 4 + unpin_pct) kind = REQ_UNPIN;
        else if (roll < 4 + unpin_pct + (96 - unpin_pct) / 2) kind = REQ_PIN;
        else kind = REQ_VICTIM;
        fr = $urandom_range(0, 1) ? FRAME_W'($urandom_range(0, 7))
                                  : FRAME_W'($urandom_range(0, 63));
        send_req(kind, fr);
      end
    end
    wait_drained();
    tx_pace = PACE_RANDOM;
    rx_pace = PACE_RANDOM;
  endtask

  task automatic test_backpressure();
    tx_pace = PACE_NONE;
    rx_pace = PACE_NONE;
    freeze_req = 150;
    for (int k = 0; k < 16; k++) send_req(REQ_UNPIN, FRAME_W'($urandom_range(0, 63)));
    for (int k = 0; k < 8; k++) send_req(REQ_VICTIM, 6'd0);
    // hold the sender until the backlog has come out
    wait_drained();
    for (int k = 0; k < 10; k++) send_req(REQ_PIN, FRAME_W'($urandom_range(0, 63)));
    repeat (10) send_req(REQ_VICTIM, 6'd0);
    wait_drained();
    tx_pace = PACE_RANDOM;
    rx_pace = PACE_RANDOM;
  endtask

  initial begin : main
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_and_drain();
    test_random_mix();
    test_backpressure();
    test_random_mix();
    in_valid <= 1'b0;
    for (int w = 0; w < 2000 && answer_q.size() != 0; w++) @(posedge clk);
    if (answer_q.size() != 0) begin
      $error("%0d expected results never arrived", answer_q.size());
      mismatches += answer_q.size();
    end
    repeat (4) @(posedge clk);
    $display("covered %0d victim, %0d pin, %0d unpin, %0d unknown requests",
             kind_seen[REQ_VICTIM], kind_seen[REQ_PIN], kind_seen[REQ_UNPIN],
             kind_seen[REQ_UNKNOWN]);
    $display("%0d results checked, %0d evictions, peak occupancy %0d, %0d mismatches",
             checked, evictions, peak_count, mismatches);
    if (mismatches == 0) begin
      $display("lru_frame_replacer_core regression: pass");
    end else begin
      $display("lru_frame_replacer_core regression: fail");
    end
    $finish;
  end

endmodule
